>>> design/ndm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ndm_pkg;

    localparam int NDM_NUM_ENTRIES = 256;
    localparam int NDM_VECTOR_LEN  = 128;
    localparam int NDM_ELEM_BITS   = 16;

    localparam int KEY_W   = 32;
    localparam int IDX_W   = 7;
    localparam int VAL_W   = 16;
    localparam int DIST_W  = 41;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 64;

    localparam logic [IDX_W-1:0]  LAST_INDEX   = 7'd127;
    localparam logic [DIST_W-1:0] DIST_MAX     = {DIST_W{1'b1}};
    localparam logic [DIST_W-1:0] THRESH_RESET = 41'd24159191;

    // register index taken from the byte address (8 bytes per register)
    localparam logic REG_THRESH = 1'b0;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_QUERY  = 2'd1,
        OP_DELETE = 2'd2,
        OP_CLEAR  = 2'd3
    } ndm_op_t;

    typedef enum logic [2:0] {
        RSP_MATCHED  = 3'd0,
        RSP_NO_MATCH = 3'd1,
        RSP_STORED   = 3'd2,
        RSP_FULL     = 3'd3,
        RSP_DELETED  = 3'd4,
        RSP_ABSENT   = 3'd5,
        RSP_CLEARED  = 3'd6
    } ndm_rsp_t;

    typedef struct packed {
        logic     take;
        logic     slot_clr;
        logic     slot_inc;
        logic     elem_clr;
        logic     elem_inc;
        logic     copy_issue;
        logic     mac_issue;
        logic     acc_clr;
        logic     best_clr;
        logic     best_upd;
        logic     commit;
        logic     key_rd;
        logic     key_best;
        logic     del_slot;
        logic     clr_all;
        logic     rsp_load;
        ndm_rsp_t rsp_code;
    } ndm_cmd_t;

    typedef struct packed {
        logic slot_valid;
        logic slot_last;
        logic elem_last;
        logic key_hit;
        logic found;
        logic pipe_busy;
        logic out_full;
    } ndm_stat_t;

endpackage
`default_nettype wire

>>> design/ndm_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface ndm_req_if
    import ndm_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [1:0]              opcode;
    logic [KEY_W-1:0]        entry_key;
    logic [IDX_W-1:0]        element_index;
    logic signed [VAL_W-1:0] element_value;

    modport source (output valid, opcode, entry_key, element_index, element_value,
                    input ready);
    modport sink   (input valid, opcode, entry_key, element_index, element_value,
                    output ready);
endinterface
`default_nettype wire

>>> design/ndm_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface ndm_rsp_if
    import ndm_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [2:0]        status;
    logic [KEY_W-1:0]  match_key;
    logic [DIST_W-1:0] sq_distance;

    modport source (output valid, status, match_key, sq_distance, input ready);
    modport sink   (input valid, status, match_key, sq_distance, output ready);
endinterface
`default_nettype wire

>>> design/ndm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module ndm_ctrl
    import ndm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      take,
    input  wire logic [1:0] opcode,
    input  wire logic      last,
    input  ndm_stat_t      stat,
    output logic           ready,
    output ndm_cmd_t       cmd
);

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_INS_SCAN = 13'b0000000000010,
        S_INS_COPY = 13'b0000000000100,
        S_INS_WAIT = 13'b0000000001000,
        S_Q_SCAN   = 13'b0000000010000,
        S_Q_MAC    = 13'b0000000100000,
        S_Q_WAIT   = 13'b0000001000000,
        S_Q_EVAL   = 13'b0000010000000,
        S_Q_DONE   = 13'b0000100000000,
        S_DEL_RD   = 13'b0001000000000,
        S_DEL_CMP  = 13'b0010000000000,
        S_RESP     = 13'b0100000000000,
        S_SPARE    = 13'b1000000000000
    } state_t;

    state_t   state_reg, state_next;
    ndm_rsp_t rsp_reg, rsp_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rsp_reg   <= RSP_CLEARED;
        end
        else
        begin
            state_reg <= state_next;
            rsp_reg   <= rsp_next;
        end
    end

    assign ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        rsp_next     = rsp_reg;
        cmd          = '0;
        cmd.take     = take;
        cmd.rsp_code = rsp_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    priority if (opcode == OP_INSERT)
                    begin
                        if (last)
                        begin
                            cmd.slot_clr = 1'b1;
                            state_next   = S_INS_SCAN;
                        end
                    end
                    else if (opcode == OP_QUERY)
                    begin
                        if (last)
                        begin
                            cmd.slot_clr = 1'b1;
                            cmd.best_clr = 1'b1;
                            state_next   = S_Q_SCAN;
                        end
                    end
                    else if (opcode == OP_DELETE)
                    begin
                        cmd.slot_clr = 1'b1;
                        state_next   = S_DEL_RD;
                    end
                    else
                    begin
                        cmd.clr_all = 1'b1;
                        rsp_next    = RSP_CLEARED;
                        state_next  = S_RESP;
                    end
                end
            end
            S_INS_SCAN:
            begin
                priority if (!stat.slot_valid)
                begin
                    cmd.elem_clr = 1'b1;
                    state_next   = S_INS_COPY;
                end
                else if (stat.slot_last)
                begin
                    rsp_next   = RSP_FULL;
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.slot_inc = 1'b1;
                end
            end
            S_INS_COPY:
            begin
                cmd.copy_issue = 1'b1;
                cmd.elem_inc   = 1'b1;
                if (stat.elem_last)
                begin
                    state_next = S_INS_WAIT;
                end
            end
            S_INS_WAIT:
            begin
                if (!stat.pipe_busy)
                begin
                    cmd.commit = 1'b1;
                    rsp_next   = RSP_STORED;
                    state_next = S_RESP;
                end
            end
            S_Q_SCAN:
            begin
                priority if (stat.slot_valid)
                begin
                    cmd.elem_clr = 1'b1;
                    cmd.acc_clr  = 1'b1;
                    state_next   = S_Q_MAC;
                end
                else if (stat.slot_last)
                begin
                    state_next = S_Q_DONE;
                end
                else
                begin
                    cmd.slot_inc = 1'b1;
                end
            end
            S_Q_MAC:
            begin
                cmd.mac_issue = 1'b1;
                cmd.elem_inc  = 1'b1;
                if (stat.elem_last)
                begin
                    state_next = S_Q_WAIT;
                end
            end
            S_Q_WAIT:
            begin
                if (!stat.pipe_busy)
                begin
                    state_next = S_Q_EVAL;
                end
            end
            S_Q_EVAL:
            begin
                cmd.best_upd = 1'b1;
                if (stat.slot_last)
                begin
                    state_next = S_Q_DONE;
                end
                else
                begin
                    cmd.slot_inc = 1'b1;
                    state_next   = S_Q_SCAN;
                end
            end
            S_Q_DONE:
            begin
                cmd.key_rd   = 1'b1;
                cmd.key_best = 1'b1;
                rsp_next     = stat.found ? RSP_MATCHED : RSP_NO_MATCH;
                state_next   = S_RESP;
            end
            S_DEL_RD:
            begin
                cmd.key_rd = 1'b1;
                state_next = S_DEL_CMP;
            end
            S_DEL_CMP:
            begin
                priority if (stat.slot_valid && stat.key_hit)
                begin
                    cmd.del_slot = 1'b1;
                    rsp_next     = RSP_DELETED;
                    state_next   = S_RESP;
                end
                else if (stat.slot_last)
                begin
                    rsp_next   = RSP_ABSENT;
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.slot_inc = 1'b1;
                    state_next   = S_DEL_RD;
                end
            end
            S_RESP:
            begin
                if (!stat.out_full)
                begin
                    cmd.rsp_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> design/ndm_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
module ndm_dpath
    import ndm_pkg::*;
#(
    parameter int NUM_ENTRIES = NDM_NUM_ENTRIES,
    parameter int VECTOR_LEN  = NDM_VECTOR_LEN,
    parameter int ELEM_BITS   = NDM_ELEM_BITS
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  ndm_cmd_t                     cmd,
    output ndm_stat_t                    stat,
    input  wire logic [1:0]              opcode,
    input  wire logic [KEY_W-1:0]        entry_key,
    input  wire logic [IDX_W-1:0]        element_index,
    input  wire logic signed [VAL_W-1:0] element_value,
    input  wire logic [DIST_W-1:0]       thresh,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [2:0]                   status,
    output logic [KEY_W-1:0]             match_key,
    output logic [DIST_W-1:0]            sq_distance
);

    localparam int SW   = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int EW   = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1;
    localparam int AW   = (NUM_ENTRIES * VECTOR_LEN > 1) ?
                          $clog2(NUM_ENTRIES * VECTOR_LEN) : 1;
    localparam int PW   = 2 * ELEM_BITS;
    localparam int SUMW = ((PW > DIST_W) ? PW : DIST_W) + 1;

    // storage
    logic [ELEM_BITS-1:0] vec_mem [NUM_ENTRIES * VECTOR_LEN];
    logic [ELEM_BITS-1:0] ins_buf [VECTOR_LEN];
    logic [ELEM_BITS-1:0] qry_buf [VECTOR_LEN];
    logic [KEY_W-1:0]     key_mem [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0] valid_reg;

    logic [SW-1:0]    slot_reg;
    logic [EW-1:0]    elem_reg;
    logic [EW-1:0]    elem_d_reg;
    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_q_reg;

    logic                        copy_v_reg;
    logic [ELEM_BITS-1:0]        ins_q_reg;
    logic                        mac_v1_reg, mac_v2_reg, mac_v3_reg;
    logic signed [ELEM_BITS-1:0] qry_q_reg, vec_q_reg;
    logic [ELEM_BITS-1:0]        mag_reg;
    logic [PW-1:0]               prod_reg;
    logic [DIST_W-1:0]           acc_reg;
    logic [DIST_W-1:0]           best_reg;
    logic [SW-1:0]               best_slot_reg;
    logic                        found_reg;

    logic                 out_valid_reg;
    logic [2:0]           status_reg;
    logic [KEY_W-1:0]     match_key_reg;
    logic [DIST_W-1:0]    dist_reg;

    logic [ELEM_BITS-1:0]        elem_in;
    logic [EW-1:0]               buf_addr;
    logic                        idx_in_range;
    logic [AW-1:0]               base_addr;
    logic signed [ELEM_BITS:0]   diff;
    logic [ELEM_BITS-1:0]        mag_next;
    logic [SUMW-1:0]             sum;
    logic [DIST_W-1:0]           acc_next;
    logic [SW-1:0]               key_addr;

    // wrap or sign-extend to the stored element width
    assign elem_in      = ELEM_BITS'(element_value);
    assign buf_addr     = EW'(element_index);
    assign idx_in_range = (32'(element_index) < 32'(VECTOR_LEN));
    assign base_addr    = AW'(32'(slot_reg) * 32'(VECTOR_LEN));
    assign key_addr     = cmd.key_best ? best_slot_reg : slot_reg;

    assign diff     = {qry_q_reg[ELEM_BITS-1], qry_q_reg}
                    - {vec_q_reg[ELEM_BITS-1], vec_q_reg};
    assign mag_next = diff[ELEM_BITS] ? ELEM_BITS'(-diff) : diff[ELEM_BITS-1:0];
    assign sum      = SUMW'(acc_reg) + SUMW'(prod_reg);
    assign acc_next = (sum > SUMW'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];

    // input buffers
    always_ff @(posedge clk)
    begin
        if (cmd.take && idx_in_range && (opcode == OP_INSERT))
        begin
            ins_buf[buf_addr] <= elem_in;
        end
        if (cmd.copy_issue)
        begin
            ins_q_reg <= ins_buf[elem_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take && idx_in_range && (opcode == OP_QUERY))
        begin
            qry_buf[buf_addr] <= elem_in;
        end
        if (cmd.mac_issue)
        begin
            qry_q_reg <= qry_buf[elem_reg];
        end
    end

    // entry vector memory, one write and one read port
    always_ff @(posedge clk)
    begin
        if (copy_v_reg)
        begin
            vec_mem[base_addr + AW'(elem_d_reg)] <= ins_q_reg;
        end
        if (cmd.mac_issue)
        begin
            vec_q_reg <= vec_mem[base_addr + AW'(elem_reg)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            key_mem[slot_reg] <= key_reg;
        end
        if (cmd.key_rd)
        begin
            key_q_reg <= key_mem[key_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            slot_reg      <= '0;
            elem_reg      <= '0;
            copy_v_reg    <= 1'b0;
            mac_v1_reg    <= 1'b0;
            mac_v2_reg    <= 1'b0;
            mac_v3_reg    <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_all)
            begin
                valid_reg <= '0;
            end
            else if (cmd.commit)
            begin
                valid_reg[slot_reg] <= 1'b1;
            end
            else if (cmd.del_slot)
            begin
                valid_reg[slot_reg] <= 1'b0;
            end

            if (cmd.slot_clr)
            begin
                slot_reg <= '0;
            end
            else if (cmd.slot_inc)
            begin
                slot_reg <= slot_reg + SW'(1);
            end

            if (cmd.elem_clr)
            begin
                elem_reg <= '0;
            end
            else if (cmd.elem_inc)
            begin
                elem_reg <= elem_reg + EW'(1);
            end

            copy_v_reg <= cmd.copy_issue;
            mac_v1_reg <= cmd.mac_issue;
            mac_v2_reg <= mac_v1_reg;
            mac_v3_reg <= mac_v2_reg;

            if (cmd.best_clr)
            begin
                found_reg <= 1'b0;
            end
            else if (cmd.best_upd && (acc_reg < thresh) && (!found_reg || acc_reg < best_reg))
            begin
                found_reg <= 1'b1;
            end

            if (cmd.rsp_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            key_reg <= entry_key;
        end
        elem_d_reg <= elem_reg;
        if (mac_v1_reg)
        begin
            mag_reg <= mag_next;
        end
        if (mac_v2_reg)
        begin
            prod_reg <= PW'(mag_reg) * PW'(mag_reg);
        end
        if (cmd.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (mac_v3_reg)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.best_upd && (acc_reg < thresh) && (!found_reg || acc_reg < best_reg))
        begin
            best_reg      <= acc_reg;
            best_slot_reg <= slot_reg;
        end
        if (cmd.rsp_load)
        begin
            status_reg <= cmd.rsp_code;
            if (cmd.rsp_code == RSP_MATCHED)
            begin
                match_key_reg <= key_q_reg;
                dist_reg      <= best_reg;
            end
            else
            begin
                match_key_reg <= '0;
                dist_reg      <= '0;
            end
        end
    end

    assign stat.slot_valid = valid_reg[slot_reg];
    assign stat.slot_last  = (32'(slot_reg) == 32'(NUM_ENTRIES - 1));
    assign stat.elem_last  = (32'(elem_reg) == 32'(VECTOR_LEN - 1));
    assign stat.key_hit    = (key_q_reg == key_reg);
    assign stat.found      = found_reg;
    assign stat.pipe_busy  = copy_v_reg | mac_v1_reg | mac_v2_reg | mac_v3_reg;
    assign stat.out_full   = out_valid_reg;

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign match_key   = match_key_reg;
    assign sq_distance = dist_reg;

endmodule
`default_nettype wire

>>> design/nearest_descriptor_match.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   dir   handshake          payload
// req       in    valid/ready        opcode, entry_key, element_index, element_value
// rsp       out   valid/ready        status, match_key, sq_distance
// apb       in    psel/penable       match_threshold_sq at byte address 0, 64-bit data
//
// ready stays high after an element transfer that is not the last of a vector
// insert commit: scans up to NUM_ENTRIES slots for a free one, then copies the vector
// query: scans every slot; each valid slot uses one shared multiply-accumulate,
//   one element per cycle; delete: reads, then compares the key of each slot scanned
// rst_n is asynchronous; it empties the table and sets the threshold to 0.6 squared
// a finished result waits in the output register while the next item is taken
module nearest_descriptor_match
    import ndm_pkg::*;
#(
    parameter int NUM_ENTRIES = NDM_NUM_ENTRIES,
    parameter int VECTOR_LEN  = NDM_VECTOR_LEN,
    parameter int ELEM_BITS   = NDM_ELEM_BITS
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    ndm_req_if.sink                req,
    ndm_rsp_if.source              rsp,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    ndm_cmd_t          cmd;
    ndm_stat_t         stat;
    logic              take;
    logic              last;
    logic [DIST_W-1:0] thresh_reg;

    // register file: only the threshold, at register index 0
    assign pready = 1'b1;
    assign prdata = (paddr[3] == REG_THRESH) ? APB_DW'(thresh_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= THRESH_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[3] == REG_THRESH))
        begin
            thresh_reg <= pwdata[DIST_W-1:0];
        end
    end

    // a transfer on req is one element or one command
    assign take = req.valid && req.ready;
    assign last = (req.element_index == LAST_INDEX);

    ndm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .opcode (req.opcode),
        .last   (last),
        .stat   (stat),
        .ready  (req.ready),
        .cmd    (cmd)
    );

    // table memories, shared multiply-accumulate and result register
    ndm_dpath #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .VECTOR_LEN  (VECTOR_LEN),
        .ELEM_BITS   (ELEM_BITS)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .opcode        (req.opcode),
        .entry_key     (req.entry_key),
        .element_index (req.element_index),
        .element_value (req.element_value),
        .thresh        (thresh_reg),
        .out_valid     (rsp.valid),
        .out_ready     (rsp.ready),
        .status        (rsp.status),
        .match_key     (rsp.match_key),
        .sq_distance   (rsp.sq_distance)
    );

endmodule
`default_nettype wire

>>> design/ndm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module ndm_checker
    import ndm_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              req_valid,
    input wire logic              req_ready,
    input wire logic [1:0]        req_opcode,
    input wire logic [IDX_W-1:0]  req_index,
    input wire logic              rsp_valid,
    input wire logic              rsp_ready,
    input wire logic [2:0]        rsp_status,
    input wire logic [KEY_W-1:0]  rsp_key,
    input wire logic [DIST_W-1:0] rsp_dist
);

    logic req_take;
    logic elem_op;

    assign req_take = req_valid && req_ready;
    assign elem_op  = (req_opcode == OP_INSERT) || (req_opcode == OP_QUERY);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped before transfer");

    a_elem_fast: assert property (@(posedge clk) disable iff (!rst_n)
        req_take && elem_op && (req_index != LAST_INDEX) |=> req_ready)
        else $error("not ready after a buffered element");

    a_commit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_take && elem_op && (req_index == LAST_INDEX) |=> !req_ready)
        else $error("ready during a vector commit");

    a_clear_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_take && (req_opcode == OP_CLEAR) && !rsp_valid |-> ##2
        (rsp_valid && (rsp_status == RSP_CLEARED)))
        else $error("clear result missing");

    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != RSP_MATCHED) |-> (rsp_key == '0) && (rsp_dist == '0))
        else $error("key or distance set without a match");

endmodule

bind nearest_descriptor_match ndm_checker u_ndm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .req_opcode (req.opcode),
    .req_index  (req.element_index),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_key    (rsp.match_key),
    .rsp_dist   (rsp.sq_distance)
);
`default_nettype wire
